/* design/ssu_pkg.sv */
// shared types and limits for the sequence statistics unit
`timescale 1ns / 1ps
`default_nettype none
package ssu_pkg;
    // widest internal fields over the supported depth range
    localparam int MAX_IW = 10;
    localparam int MAX_CW = 11;
    localparam int MAX_SW = 32 + MAX_CW;

    // store write from the front part
    typedef struct packed {
        logic              en;
        logic [MAX_IW-1:0] addr;
        logic [31:0]       data;
    } t_wr;

    // one closed sequence handed to the back part
    typedef struct packed {
        logic signed [MAX_SW-1:0] sum;
        logic signed [31:0]       max_v;
        logic signed [31:0]       min_v;
        logic [MAX_IW-1:0]        gap;
        logic [MAX_CW-1:0]        count;
        logic                     drop;
    } t_job;
endpackage
`default_nettype wire

/* design/ssu_front.sv */
// front part: stores items and keeps running sum, extremes and first indices
`timescale 1ns / 1ps
`default_nettype none
module ssu_front #(
    parameter int DEPTH = 64
) (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_valid,
    input  wire                logic [31:0] i_sample,
    input  wire                logic i_final_req,
    input  wire                logic i_release,
    output logic               o_stall,
    output ssu_pkg::t_wr       o_wr,
    output logic               o_push,
    output ssu_pkg::t_job      o_job
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = 32 + CW;

    logic [CW-1:0]        r_count, n_count;
    logic                 r_drop, n_drop;
    logic                 r_hold, n_hold;
    logic signed [SW-1:0] r_sum, n_sum;
    logic signed [31:0]   r_max, n_max, r_min, n_min;
    logic [IW-1:0]        r_imax, n_imax, r_imin, n_imin;
    logic                 accept;
    logic                 room;
    logic [IW-1:0]        gap;

    assign o_stall = r_hold;
    assign accept  = i_valid && !r_hold;
    assign room    = r_count < CW'(DEPTH);

    // running statistics, cleared once a sequence closes
    always_comb begin
        n_count = r_count;
        n_drop  = r_drop;
        n_hold  = r_hold;
        n_sum   = r_sum;
        n_max   = r_max;
        n_min   = r_min;
        n_imax  = r_imax;
        n_imin  = r_imin;
        o_wr.en   = 1'b0;
        o_wr.addr = ssu_pkg::MAX_IW'(r_count[IW-1:0]);
        o_wr.data = i_sample;
        if (accept) begin
            if (room) begin
                o_wr.en = 1'b1;
                n_count = r_count + 1'b1;
                n_sum   = r_sum + {{(SW-32){i_sample[31]}}, i_sample};
                if (r_count == '0) begin
                    n_max  = i_sample;
                    n_min  = i_sample;
                    n_imax = '0;
                    n_imin = '0;
                end else begin
                    if ($signed(i_sample) > r_max) begin
                        n_max  = i_sample;
                        n_imax = r_count[IW-1:0];
                    end
                    if ($signed(i_sample) < r_min) begin
                        n_min  = i_sample;
                        n_imin = r_count[IW-1:0];
                    end
                end
            end else begin
                n_drop = 1'b1;
            end
        end
        gap = (n_imax >= n_imin) ? (n_imax - n_imin) : (n_imin - n_imax);
        o_job.sum   = ssu_pkg::MAX_SW'(n_sum);
        o_job.max_v = n_max;
        o_job.min_v = n_min;
        o_job.gap   = ssu_pkg::MAX_IW'(gap);
        o_job.count = ssu_pkg::MAX_CW'(n_count);
        o_job.drop  = n_drop;
        o_push      = accept && i_final_req;
        if (o_push) begin
            n_count = '0;
            n_drop  = 1'b0;
            n_sum   = '0;
            n_hold  = 1'b1;
        end
        if (i_release) begin
            n_hold = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
            r_hold  <= 1'b0;
            r_sum   <= '0;
        end else begin
            r_count <= n_count;
            r_drop  <= n_drop;
            r_hold  <= n_hold;
            r_sum   <= n_sum;
        end
    end

    // extremes and their first indices
    always_ff @(posedge i_clk) begin
        r_max  <= n_max;
        r_min  <= n_min;
        r_imax <= n_imax;
        r_imin <= n_imin;
    end
endmodule
`default_nettype wire

/* design/ssu_fifo.sv */
// two-entry queue of closed sequences between front and back
`timescale 1ns / 1ps
`default_nettype none
module ssu_fifo (
    input  wire           logic i_clk,
    input  wire           logic i_rst_n,
    input  wire           logic i_push,
    input  ssu_pkg::t_job i_job,
    input  wire           logic i_pop,
    output logic          o_nonempty,
    output ssu_pkg::t_job o_job
);
    ssu_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_fill;

    assign o_nonempty = r_fill != 2'd0;
    assign o_job      = r_mem[r_rp];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_fill <= r_fill + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end
endmodule
`default_nettype wire

/* design/ssu_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ssu_div #(
    parameter int W  = 39,
    parameter int DW = 7
) (
    input  wire    logic i_clk,
    input  wire    logic i_rst_n,
    input  wire    logic i_start,
    input  wire    logic [W-1:0] i_dividend,
    input  wire    logic [DW-1:0] i_divisor,
    output logic   o_done,
    output logic   [W-1:0] o_quot
);
    localparam int KW = $clog2(W + 1);

    logic [W-1:0]  r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_d;
    logic [KW-1:0] r_k;
    logic          r_busy, r_done;
    logic [DW:0]   rem_sh;
    logic          take;

    assign o_done = r_done;
    assign o_quot = r_q;
    assign rem_sh = {r_rem[DW-1:0], r_q[W-1]};
    assign take   = rem_sh >= {1'b0, r_d};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_k    <= KW'(W);
        end else if (r_busy) begin
            r_k <= r_k - 1'b1;
            if (r_k == KW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? (rem_sh - {1'b0, r_d}) : rem_sh;
            r_q   <= {r_q[W-2:0], take};
        end
    end
endmodule
`default_nettype wire

/* design/ssu_back.sv */
// back part: element store, mode search, mean and the result register
`timescale 1ns / 1ps
`default_nettype none
module ssu_back #(
    parameter int DEPTH = 64
) (
    input  wire           logic i_clk,
    input  wire           logic i_rst_n,
    input  ssu_pkg::t_wr  i_wr,
    input  wire           logic i_job_valid,
    input  ssu_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_release,
    input  wire           logic i_stall,
    output logic          o_valid,
    output logic          [37:0] o_total,
    output logic          [31:0] o_largest,
    output logic          [31:0] o_smallest,
    output logic          [5:0] o_extreme_gap,
    output logic          [31:0] o_mean,
    output logic          o_repeats_seen,
    output logic          [31:0] o_most_frequent,
    output logic          [6:0] o_element_count,
    output logic          o_overflowed
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = 32 + CW;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_WAIT  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state               r_state;
    logic [31:0]          r_mem [DEPTH];
    logic [31:0]          r_rd_a, r_rd_b;
    logic [IW-1:0]        r_i, r_j;
    logic [CW-1:0]        r_n, r_cnt, r_best_cnt;
    logic                 r_pv, r_plast;
    logic [31:0]          r_best_val;
    ssu_pkg::t_job        r_job;
    logic                 r_ov;
    logic                 match;
    logic [CW-1:0]        cnt_tot;
    logic                 j_last, i_last;
    logic signed [SW-1:0] job_sum;
    logic                 neg;
    logic [SW-1:0]        mag;
    logic                 div_done;
    logic [SW-1:0]        quot;
    logic [SW-1:0]        mean_full;
    logic                 load_out;

    assign o_pop     = (r_state == S_IDLE) && i_job_valid;
    assign load_out  = (r_state == S_OUT) && (!r_ov || !i_stall);
    assign o_release = load_out;
    assign o_valid   = r_ov;
    assign match     = r_rd_a == r_rd_b;
    assign cnt_tot   = r_cnt + CW'(match);
    assign j_last    = CW'(r_j) == r_n - 1'b1;
    assign i_last    = CW'(r_i) == r_n - 1'b1;
    assign job_sum   = SW'(i_job.sum);
    assign neg       = job_sum[SW-1];
    assign mag       = neg ? SW'(-job_sum) : SW'(job_sum);
    assign mean_full = r_job.sum[ssu_pkg::MAX_SW-1] ? (~quot + 1'b1) : quot;

    // mean as a magnitude division
    ssu_div #(.W(SW), .DW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (o_pop),
        .i_dividend (mag),
        .i_divisor  (CW'(i_job.count)),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // element store with two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[i_wr.addr[IW-1:0]] <= i_wr.data;
        r_rd_a <= r_mem[r_i];
        r_rd_b <= r_mem[r_j];
    end

    // sequencer over all index pairs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_pv <= (r_state == S_SCAN);
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (j_last && i_last) r_state <= S_DRAIN;
                end
                S_DRAIN: r_state <= S_WAIT;
                S_WAIT: begin
                    if (div_done) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (load_out) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // pair indices and occurrence counting
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job      <= i_job;
            r_n        <= CW'(i_job.count);
            r_i        <= '0;
            r_j        <= '0;
            r_cnt      <= '0;
            r_best_cnt <= '0;
        end else begin
            if (r_state == S_SCAN) begin
                r_plast <= j_last;
                if (j_last) begin
                    r_j <= '0;
                    if (!i_last) r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (r_pv) begin
                if (r_plast) begin
                    r_cnt <= '0;
                    if (cnt_tot > r_best_cnt) begin
                        r_best_cnt <= cnt_tot;
                        r_best_val <= r_rd_a;
                    end
                end else begin
                    r_cnt <= cnt_tot;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_total         <= r_job.sum[37:0];
            o_largest       <= r_job.max_v;
            o_smallest      <= r_job.min_v;
            o_extreme_gap   <= r_job.gap[5:0];
            o_mean          <= mean_full[31:0];
            o_repeats_seen  <= r_best_cnt >= CW'(2);
            o_most_frequent <= r_best_val;
            o_element_count <= 7'(r_job.count);
            o_overflowed    <= r_job.drop;
        end
    end

    a_best_le_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (r_best_cnt <= r_n && r_best_cnt != '0))
        else $error("mode count out of range");
    a_out_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> div_done)
        else $error("result formed before division finished");
    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_i) < r_n && CW'(r_j) < r_n))
        else $error("scan index beyond stored count");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_SCAN))
        else $error("job taken outside idle");
endmodule
`default_nettype wire

/* design/sequence_statistics_unit.sv */
// top level of the sequence statistics unit
//
// Input channel (i_valid / o_stall) carries one item: a signed 32-bit
// sample and a final flag. Samples are stored in order, up to DEPTH of
// them; later ones are dropped and reported as overflowed. The item with
// the final flag closes the sequence and causes one result item on the
// output channel (o_valid / i_stall) with sum, max, min, gap between their
// first indices, mean truncated toward zero, duplicate flag, mode, count.
// Items load one per cycle while o_stall is low. After the final item the
// front stalls until the result register is loaded; meanwhile the back
// searches for the mode: every pair of stored elements is compared on one
// comparator. o_valid rises once the mode search and the mean divider,
// which runs alongside it, are done and the output register is free.
// The result sits in an output register; the next sequence may load while
// it waits under i_stall, but its own result waits for that register.
// Reset empties the store count and clears all valid state.
`timescale 1ns / 1ps
`default_nettype none
module sequence_statistics_unit #(
    parameter int DEPTH = 64
) (
    input  wire  logic i_clk,
    input  wire  logic i_rst_n,
    input  wire  logic i_valid,
    output logic o_stall,
    input  wire  logic [31:0] i_sample,
    input  wire  logic i_final_req,
    output logic o_valid,
    input  wire  logic i_stall,
    output logic [37:0] o_total,
    output logic [31:0] o_largest,
    output logic [31:0] o_smallest,
    output logic [5:0] o_extreme_gap,
    output logic [31:0] o_mean,
    output logic o_repeats_seen,
    output logic [31:0] o_most_frequent,
    output logic [6:0] o_element_count,
    output logic o_overflowed
);
    ssu_pkg::t_wr  wr;
    ssu_pkg::t_job job_in, job_out;
    logic          push, pop, nonempty, release_hold;

    // item intake and running statistics
    ssu_front #(.DEPTH(DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_sample    (i_sample),
        .i_final_req (i_final_req),
        .i_release   (release_hold),
        .o_stall     (o_stall),
        .o_wr        (wr),
        .o_push      (push),
        .o_job       (job_in)
    );

    // closed sequences waiting for the back part
    ssu_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (job_in),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_job      (job_out)
    );

    // mode search, mean and result
    ssu_back #(.DEPTH(DEPTH)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (wr),
        .i_job_valid     (nonempty),
        .i_job           (job_out),
        .o_pop           (pop),
        .o_release       (release_hold),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_total         (o_total),
        .o_largest       (o_largest),
        .o_smallest      (o_smallest),
        .o_extreme_gap   (o_extreme_gap),
        .o_mean          (o_mean),
        .o_repeats_seen  (o_repeats_seen),
        .o_most_frequent (o_most_frequent),
        .o_element_count (o_element_count),
        .o_overflowed    (o_overflowed)
    );
endmodule
`default_nettype wire

/* tb/sequence_statistics_unit_tb.sv */
// self-checking testbench for the sequence statistics unit
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
    logic [37:0] total;
    logic [31:0] largest;
    logic [31:0] smallest;
    logic [5:0]  extreme_gap;
    logic [31:0] mean;
    logic        repeats_seen;
    logic [31:0] most_frequent;
    logic [6:0]  element_count;
    logic        overflowed;
} t_stats;

class stats_scoreboard;
    localparam int DEPTH = 64;
    logic [31:0] seq_store[DEPTH];
    int          seq_len;
    bit          seq_dropped;
    t_stats      pending[$];
    int          errors;

    function new();
        seq_len = 0;
        seq_dropped = 0;
        errors = 0;
    endfunction

    // note an accepted input item; close the sequence on the final flag
    function void note_sample(logic [31:0] smp, logic fin);
        longint sum, mx, mn, v;
        int imax, imin, best_cnt, best_idx, cnt;
        t_stats r;
        if (seq_len < DEPTH) begin
            seq_store[seq_len] = smp;
            seq_len++;
        end else begin
            seq_dropped = 1;
        end
        if (!fin) return;
        sum = 0;
        mx = longint'($signed(seq_store[0]));
        mn = mx;
        imax = 0;
        imin = 0;
        for (int i = 0; i < seq_len; i++) begin
            v = longint'($signed(seq_store[i]));
            sum += v;
            if (v > mx) begin
                mx = v;
                imax = i;
            end
            if (v < mn) begin
                mn = v;
                imin = i;
            end
        end
        best_cnt = 0;
        best_idx = 0;
        for (int i = 0; i < seq_len; i++) begin
            cnt = 0;
            for (int j = 0; j < seq_len; j++)
                if (seq_store[i] == seq_store[j]) cnt++;
            if (cnt > best_cnt) begin
                best_cnt = cnt;
                best_idx = i;
            end
        end
        r.total = sum[37:0];
        r.largest = mx[31:0];
        r.smallest = mn[31:0];
        r.extreme_gap = 6'((imax >= imin) ? imax - imin : imin - imax);
        v = sum / seq_len;
        r.mean = v[31:0];
        r.repeats_seen = best_cnt >= 2;
        r.most_frequent = seq_store[best_idx];
        r.element_count = 7'(seq_len);
        r.overflowed = seq_dropped;
        pending.push_back(r);
        seq_len = 0;
        seq_dropped = 0;
    endfunction

    // compare one result item with the oldest expectation
    function void check_result(t_stats got);
        t_stats e;
        if (pending.size() == 0) begin
            $display("%0t unexpected result item total=%h", $time, got.total);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.total !== e.total) begin
            $display("%0t total exp %h got %h", $time, e.total, got.total); errors++;
        end
        if (got.largest !== e.largest) begin
            $display("%0t largest exp %h got %h", $time, e.largest, got.largest); errors++;
        end
        if (got.smallest !== e.smallest) begin
            $display("%0t smallest exp %h got %h", $time, e.smallest, got.smallest);
            errors++;
        end
        if (got.extreme_gap !== e.extreme_gap) begin
            $display("%0t gap exp %0d got %0d", $time, e.extreme_gap, got.extreme_gap);
            errors++;
        end
        if (got.mean !== e.mean) begin
            $display("%0t mean exp %h got %h", $time, e.mean, got.mean); errors++;
        end
        if (got.repeats_seen !== e.repeats_seen) begin
            $display("%0t repeats exp %b got %b", $time, e.repeats_seen, got.repeats_seen);
            errors++;
        end
        if (got.most_frequent !== e.most_frequent) begin
            $display("%0t mode exp %h got %h", $time, e.most_frequent, got.most_frequent);
            errors++;
        end
        if (got.element_count !== e.element_count) begin
            $display("%0t count exp %0d got %0d", $time, e.element_count,
                     got.element_count);
            errors++;
        end
        if (got.overflowed !== e.overflowed) begin
            $display("%0t overflow exp %b got %b", $time, e.overflowed, got.overflowed);
            errors++;
        end
    endfunction
endclass

module sequence_statistics_unit_tb;
    localparam int LIMIT = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_sample;
    logic        i_final_req;
    logic        o_valid;
    logic        i_stall;
    logic [37:0] o_total;
    logic [31:0] o_largest;
    logic [31:0] o_smallest;
    logic [5:0]  o_extreme_gap;
    logic [31:0] o_mean;
    logic        o_repeats_seen;
    logic [31:0] o_most_frequent;
    logic [6:0]  o_element_count;
    logic        o_overflowed;

    stats_scoreboard sb;
    int  cycles;
    bit  calm;      // no idling on either side
    bit  src_done;

    sequence_statistics_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_sample(i_sample), .i_final_req(i_final_req), .o_valid(o_valid),
        .i_stall(i_stall), .o_total(o_total), .o_largest(o_largest),
        .o_smallest(o_smallest), .o_extreme_gap(o_extreme_gap), .o_mean(o_mean),
        .o_repeats_seen(o_repeats_seen), .o_most_frequent(o_most_frequent),
        .o_element_count(o_element_count), .o_overflowed(o_overflowed)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_sample = 0;
        i_final_req = 0;
        i_stall = 0;
        sb = new();
        cycles = 0;
        calm = 0;
        src_done = 0;
    end

    // sink side: random stall, check each accepted result item
    always @(posedge i_clk) begin
        t_stats got;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            got.total = o_total;
            got.largest = o_largest;
            got.smallest = o_smallest;
            got.extreme_gap = o_extreme_gap;
            got.mean = o_mean;
            got.repeats_seen = o_repeats_seen;
            got.most_frequent = o_most_frequent;
            got.element_count = o_element_count;
            got.overflowed = o_overflowed;
            sb.check_result(got);
        end
        i_stall <= calm ? 1'b0 : ($urandom_range(99) < 28);
        if (cycles > LIMIT) begin
            $display("[sequence_statistics_unit] ERROR");
            $finish;
        end
    end

    // present one item and hold it until accepted; valid stays high after
    task automatic send_item(logic [31:0] smp, logic fin);
        while (!calm && $urandom_range(99) < 28) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= smp;
        i_final_req <= fin;
        do @(posedge i_clk); while (o_stall);
        sb.note_sample(smp, fin);
    endtask

    // drop valid and wait until every expected result item has come
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value(int mode);
        case (mode)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(7);
            3: return -$urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    // one sequence of given length, values drawn by the given mode
    task automatic send_seq(int len, int mode);
        for (int k = 0; k < len; k++)
            send_item(rand_value(mode == 9 ? $urandom_range(5) : mode), k == len - 1);
    endtask

    initial begin
        int len;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: single elements at the extremes
        send_item(32'h7fffffff, 1);
        send_item(32'h80000000, 1);
        send_item(32'h00000000, 1);
        // max before min, repeated minimum, ties for mode
        send_item(32'h7fffffff, 0);
        send_item(32'h80000000, 0);
        send_item(32'h80000000, 1);
        send_item(32'd5, 0);
        send_item(32'd3, 0);
        send_item(32'd3, 0);
        send_item(32'd5, 1);
        // negative mean truncating toward zero
        send_item(-32'sd7, 0);
        send_item(32'd2, 1);
        // all distinct
        send_item(32'd1, 0);
        send_item(32'd2, 0);
        send_item(32'd3, 1);
        // pause until drained
        drain();
        // full store and overflow, final item dropped
        send_seq(64, 0);
        send_seq(66, 1);
        send_seq(64, 4);
        // random sequences, mostly short
        for (int s = 0; s < 95; s++) begin
            calm = (s >= 30 && s < 42);
            if (s == 60) drain();
            len = ($urandom_range(9) == 0) ? $urandom_range(70, 60) : $urandom_range(1, 16);
            send_seq(len, 9);
        end
        i_valid <= 1'b0;
        calm = 0;
        src_done = 1;
    end

    // end of run
    initial begin
        wait (src_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (5000) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[sequence_statistics_unit] OK");
        end else begin
            $display("[sequence_statistics_unit] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sequence_statistics_unit.f */
design/ssu_pkg.sv
design/ssu_front.sv
design/ssu_fifo.sv
design/ssu_div.sv
design/ssu_back.sv
design/sequence_statistics_unit.sv
tb/sequence_statistics_unit_tb.sv
